// ===== design/edf_pkg.sv =====
// Shared types and constants for the earliest-deadline-first scheduler.
package edf_pkg;

  localparam int SLOTS          = 16;
  localparam int SLOT_W         = $clog2(SLOTS);
  localparam int CNT_W          = $clog2(SLOTS + 1);
  localparam int DEADLINE_LIMIT = 10000;

  localparam int TIME_W  = 16;
  localparam int DL_W    = 14;
  localparam int SLOTF_W = 4;
  localparam int EVENT_W = 3;

  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
  localparam logic [EVENT_W-1:0] EV_ACCEPTED = 3'd1;
  localparam logic [EVENT_W-1:0] EV_FULL     = 3'd2;
  localparam logic [EVENT_W-1:0] EV_STARTED  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_DONE     = 3'd4;

  typedef struct packed {
    logic [DL_W-1:0]   deadline;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] start_time;
  } slot_rec_t;

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_rec_t         wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
  } ram_req_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_res;
    logic [SLOTF_W-1:0] slot;
    logic [TIME_W-1:0]  arrival_time;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  complete_time;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  wait_time;
    logic               deadline_met;
  } sched_res_t;

  // The reported slot carries the full slot number.
  function automatic logic [SLOTF_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
    return SLOTF_W'(idx);
  endfunction

endpackage

// ===== design/nonpreemptive_edf_scheduler.sv =====
// Top level: sequencer, deadline scan unit and result register of the EDF scheduler.
//
//  Channel | Direction | Contents
//  s_*     | in        | tuser: kind; tdata: svc_units, deadline
//  m_*     | out       | tuser: event_res; tdata: slot, times, deadline_met
//
// An arrival goes from idle straight to the result state. A tick with a task
// running reads the slot, updates it and gives the result. A tick that selects
// scans first, one slot record per cycle through the single memory read port.
// Reset is synchronous and clears the ready bits, slot count, time and running
// task. A stalled result waits in the output register; the next request is
// taken meanwhile, and its own result waits until that register frees up.
module nonpreemptive_edf_scheduler import edf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        s_tuser,   // [0] kind
  input  logic [31:0] s_tdata,   // [15:0] svc_units, [29:16] deadline
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [2:0]  m_tuser,   // [2:0] event_res
  output logic [87:0] m_tdata    // [3:0] slot, [19:4] arrival_time, [35:20] start_time,
                                 // [51:36] complete_time, [67:52] turnaround,
                                 // [83:68] wait_time, [84] deadline_met
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_RDRUN = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]        state;
  logic [SLOTS-1:0]  slot_ready;
  logic [CNT_W-1:0]  slots_used;
  logic              running_valid;
  logic [SLOT_W-1:0] running_slot;
  logic [TIME_W-1:0] cur_time;
  logic              started;

  logic [CNT_W-1:0]  issue_idx;
  logic              chk_valid;
  logic [SLOT_W-1:0] chk_idx;
  logic [DL_W-1:0]   best;
  logic              found;
  logic [SLOT_W-1:0] pick;

  slot_rec_t  cur;
  sched_res_t res_pend;
  sched_res_t res_out;
  ram_req_t   req;
  slot_rec_t  rd_data;

  logic              in_fire;
  logic              in_kind;
  logic [TIME_W-1:0] in_service;
  logic [DL_W-1:0]   in_deadline;
  logic              table_full;
  logic              scan_issue;
  logic              scan_take;
  logic              finishing;
  logic              out_load;
  logic [TIME_W-1:0] done_time;
  logic [TIME_W-1:0] ta;
  logic [TIME_W-1:0] wt;
  sched_res_t        run_res;
  sched_res_t        arr_res;

  assign s_tready    = (state == ST_IDLE);
  assign in_fire     = s_tvalid && s_tready;
  assign in_kind     = s_tuser;
  assign in_service  = s_tdata[15:0];
  assign in_deadline = s_tdata[29:16];
  assign table_full  = (slots_used >= CNT_W'(SLOTS));
  assign scan_issue  = (issue_idx < slots_used);
  assign out_load    = (state == ST_OUT) && (!m_tvalid || m_tready);

  // Shared compare unit: one slot record is checked per cycle during the scan.
  assign scan_take = chk_valid && slot_ready[chk_idx] && (rd_data.deadline <= best);

  assign finishing = (cur.remaining <= TIME_W'(1));
  assign done_time = cur_time + TIME_W'(1);
  assign ta        = done_time - cur.arrival_time;
  assign wt        = cur.start_time - cur.arrival_time;

  always_comb begin
    run_res = '0;
    if (finishing) begin
      run_res.event_res     = EV_DONE;
      run_res.slot          = slot_field(running_slot);
      run_res.arrival_time  = cur.arrival_time;
      run_res.start_time    = cur.start_time;
      run_res.complete_time = done_time;
      run_res.turnaround    = ta;
      run_res.wait_time     = wt;
      run_res.deadline_met  = (ta <= TIME_W'(cur.deadline));
    end else if (started) begin
      run_res.event_res = EV_STARTED;
      run_res.slot      = slot_field(running_slot);
    end
  end

  always_comb begin
    arr_res = '0;
    if (table_full) begin
      arr_res.event_res = EV_FULL;
    end else begin
      arr_res.event_res = EV_ACCEPTED;
      arr_res.slot      = slot_field(slots_used[SLOT_W-1:0]);
    end
  end

  always_comb begin
    req = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && (in_kind == KIND_ARRIVE) && !table_full) begin
          req.wr_en                  = 1'b1;
          req.wr_addr                = slots_used[SLOT_W-1:0];
          req.wr_data.deadline       = in_deadline;
          req.wr_data.remaining      = in_service;
          req.wr_data.arrival_time   = cur_time;
          req.wr_data.start_time     = '0;
        end else if (in_fire && (in_kind == KIND_TICK) && running_valid) begin
          req.rd_en   = 1'b1;
          req.rd_addr = running_slot;
        end
      end
      ST_SCAN: begin
        req.rd_en   = scan_issue;
        req.rd_addr = issue_idx[SLOT_W-1:0];
      end
      ST_RUN: begin
        req.wr_en             = 1'b1;
        req.wr_addr           = running_slot;
        req.wr_data           = cur;
        req.wr_data.remaining = finishing ? '0 : cur.remaining - TIME_W'(1);
      end
      ST_RDRUN, ST_OUT: begin
        req = '0;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  edf_slot_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      slot_ready    <= '0;
      slots_used    <= '0;
      running_valid <= 1'b0;
      running_slot  <= '0;
      cur_time      <= '0;
      started       <= 1'b0;
      chk_valid     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_kind == KIND_ARRIVE) begin
              res_pend <= arr_res;
              if (!table_full) begin
                slot_ready[slots_used[SLOT_W-1:0]] <= 1'b1;
                slots_used <= slots_used + CNT_W'(1);
              end
              state <= ST_OUT;
            end else if (running_valid) begin
              started <= 1'b0;
              state   <= ST_RDRUN;
            end else begin
              issue_idx <= '0;
              chk_valid <= 1'b0;
              best      <= DL_W'(DEADLINE_LIMIT);
              found     <= 1'b0;
              state     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_issue) begin
            issue_idx <= issue_idx + CNT_W'(1);
            chk_idx   <= issue_idx[SLOT_W-1:0];
          end
          chk_valid <= scan_issue;
          if (scan_take) begin
            best  <= rd_data.deadline;
            pick  <= chk_idx;
            cur   <= rd_data;
            found <= 1'b1;
          end
          // The scan ends once every read has been issued and checked.
          if (!scan_issue && !chk_valid) begin
            if (found) begin
              slot_ready[pick] <= 1'b0;
              running_valid    <= 1'b1;
              running_slot     <= pick;
              cur.start_time   <= cur_time;
              started          <= 1'b1;
              state            <= ST_RUN;
            end else begin
              res_pend <= '0;
              cur_time <= cur_time + TIME_W'(1);
              state    <= ST_OUT;
            end
          end
        end
        ST_RDRUN: begin
          cur   <= rd_data;
          state <= ST_RUN;
        end
        ST_RUN: begin
          res_pend <= run_res;
          if (finishing) begin
            running_valid <= 1'b0;
          end
          cur_time <= cur_time + TIME_W'(1);
          state    <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            res_out <= res_pend;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tuser = res_out.event_res;
  assign m_tdata = {3'b000, res_out.deadline_met, res_out.wait_time, res_out.turnaround,
                    res_out.complete_time, res_out.start_time, res_out.arrival_time,
                    res_out.slot};

endmodule

// ===== design/edf_slot_ram.sv =====
// Task slot record memory with one write port and one registered read port.
module edf_slot_ram import edf_pkg::*; (
  input  logic      clk,
  input  ram_req_t  req,
  output slot_rec_t rd_data
);

  slot_rec_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== tb/edf_schedule_checker.sv =====
// Request/result checker for the EDF scheduler: predicts each event and compares.
module edf_schedule_checker import edf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic        s_tuser,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [2:0]  m_tuser,
  input  logic [87:0] m_tdata,
  output int          mismatches,
  output int          events_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the scheduler state.
  logic              task_ready    [SLOTS];
  logic [DL_W-1:0]   task_deadline [SLOTS];
  logic [TIME_W-1:0] task_remaining[SLOTS];
  logic [TIME_W-1:0] task_entered  [SLOTS];
  logic [TIME_W-1:0] task_started  [SLOTS];
  int                tasks_stored;
  logic              task_running;
  int                running_task;
  logic [TIME_W-1:0] now;

  sched_res_t expected_events[$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (got !== want) report_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
  endtask

  // Runs task s for one time unit; on completion fills in the report and returns 1.
  function automatic bit run_one_unit(input int s, inout sched_res_t ev);
    logic [TIME_W-1:0] done_at;
    logic [TIME_W-1:0] turnaround;
    if (task_remaining[s] > 1) begin
      task_remaining[s] = task_remaining[s] - 1'b1;
      return 1'b0;
    end
    task_remaining[s] = '0;
    task_running      = 1'b0;
    done_at           = now + 1'b1;
    turnaround        = done_at - task_entered[s];
    ev.event_res      = EV_DONE;
    ev.slot           = SLOTF_W'(s);
    ev.arrival_time   = task_entered[s];
    ev.start_time     = task_started[s];
    ev.complete_time  = done_at;
    ev.turnaround     = turnaround;
    ev.wait_time      = task_started[s] - task_entered[s];
    ev.deadline_met   = (turnaround <= TIME_W'(task_deadline[s]));
    return 1'b1;
  endfunction

  function automatic sched_res_t predict_event(input logic kind,
                                               input logic [TIME_W-1:0] service,
                                               input logic [DL_W-1:0] deadline);
    sched_res_t ev;
    int         best;
    int         pick;
    bit         found;
    ev = '0;
    if (kind == KIND_ARRIVE) begin
      if (tasks_stored < SLOTS) begin
        task_remaining[tasks_stored] = service;
        task_deadline[tasks_stored]  = deadline;
        task_entered[tasks_stored]   = now;
        task_ready[tasks_stored]     = 1'b1;
        ev.event_res                 = EV_ACCEPTED;
        ev.slot                      = SLOTF_W'(tasks_stored);
        tasks_stored++;
      end else begin
        ev.event_res = EV_FULL;
      end
      return ev;
    end
    if (task_running) begin
      void'(run_one_unit(running_task, ev));
    end else begin
      // Ties go to the highest slot, hence the <= in the scan.
      best  = DEADLINE_LIMIT;
      pick  = 0;
      found = 1'b0;
      for (int i = 0; i < tasks_stored; i++) begin
        if (task_ready[i] && int'(task_deadline[i]) <= best) begin
          best  = int'(task_deadline[i]);
          pick  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        task_ready[pick]   = 1'b0;
        task_running       = 1'b1;
        running_task       = pick;
        task_started[pick] = now;
        if (!run_one_unit(pick, ev)) begin
          ev.event_res = EV_STARTED;
          ev.slot      = SLOTF_W'(pick);
        end
      end
    end
    now = now + 1'b1;
    return ev;
  endfunction

  always @(posedge clk) begin
    sched_res_t want;
    sched_res_t got;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        task_ready[i]     = 1'b0;
        task_deadline[i]  = '0;
        task_remaining[i] = '0;
        task_entered[i]   = '0;
        task_started[i]   = '0;
      end
      tasks_stored = 0;
      task_running = 1'b0;
      running_task = 0;
      now          = '0;
      mismatches   = 0;
      expected_events.delete();
    end else begin
      if (s_tvalid && s_tready)
        expected_events.push_back(predict_event(s_tuser, s_tdata[15:0], s_tdata[29:16]));
      if (m_tvalid && m_tready) begin
        got.event_res     = m_tuser;
        got.slot          = m_tdata[3:0];
        got.arrival_time  = m_tdata[19:4];
        got.start_time    = m_tdata[35:20];
        got.complete_time = m_tdata[51:36];
        got.turnaround    = m_tdata[67:52];
        got.wait_time     = m_tdata[83:68];
        got.deadline_met  = m_tdata[84];
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting, event %0d", got.event_res));
        end else begin
          want = expected_events.pop_front();
          check_field("event_res", TIME_W'(want.event_res), TIME_W'(got.event_res));
          check_field("slot", TIME_W'(want.slot), TIME_W'(got.slot));
          check_field("arrival_time", want.arrival_time, got.arrival_time);
          check_field("start_time", want.start_time, got.start_time);
          check_field("complete_time", want.complete_time, got.complete_time);
          check_field("turnaround", want.turnaround, got.turnaround);
          check_field("wait_time", want.wait_time, got.wait_time);
          check_field("deadline_met", TIME_W'(want.deadline_met), TIME_W'(got.deadline_met));
        end
      end
    end
    events_pending = expected_events.size();
  end

endmodule

// ===== tb/nonpreemptive_edf_scheduler_tb.sv =====
// Testbench top for the EDF scheduler: clock, reset, request stimulus and verdict.
module nonpreemptive_edf_scheduler_tb;
  import edf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic        s_tuser;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [2:0]  m_tuser;
  logic [87:0] m_tdata;

  int mismatches;
  int events_pending;
  int burst_left;
  int gap_max;
  bit hold_off_due;

  nonpreemptive_edf_scheduler u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  edf_schedule_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tuser        (s_tuser),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tuser        (m_tuser),
    .m_tdata        (m_tdata),
    .mismatches     (mismatches),
    .events_pending (events_pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Offers one request and returns in the step in which it was taken.
  // Requests go out in bursts with random gaps between them.
  task automatic offer(input logic kind, input logic [TIME_W-1:0] service,
                       input logic [DL_W-1:0] deadline);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, deadline, service};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic tick();
    offer(KIND_TICK, TIME_W'($urandom), DL_W'($urandom));
  endtask

  task automatic random_arrival();
    logic [DL_W-1:0]   deadline;
    logic [TIME_W-1:0] service;
    // Mostly small deadlines so ties and missed deadlines are common; the rest
    // sit around or above the limit. Long tasks are only given unselectable
    // deadlines so they never stall the run.
    if ($urandom_range(0, 3) != 0) deadline = DL_W'($urandom_range(0, 40));
    else deadline = DL_W'($urandom_range(DEADLINE_LIMIT - 10, 16383));
    if (deadline > DEADLINE_LIMIT) service = TIME_W'($urandom);
    else service = TIME_W'($urandom_range(0, 12));
    offer(KIND_ARRIVE, service, deadline);
  endtask

  // Receiver: ready patterns of random length, plus one long hold-off on request.
  initial begin
    int seg;
    int mode;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(8, 60);
      repeat (seg) begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int guard;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tuser      = KIND_ARRIVE;
    s_tdata      = '0;
    burst_left   = 0;
    gap_max      = 4;
    hold_off_due = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    tick();                                    // nothing stored yet: idle
    offer(KIND_ARRIVE, 16'd0, 14'd0);          // zero service, deadline will be missed
    offer(KIND_ARRIVE, 16'd1, 14'd5);
    offer(KIND_ARRIVE, 16'hFFFF, 14'h3FFF);    // all ones, never selectable
    offer(KIND_ARRIVE, 16'd3, DL_W'(DEADLINE_LIMIT + 1));
    offer(KIND_ARRIVE, 16'd2, DL_W'(DEADLINE_LIMIT));
    offer(KIND_ARRIVE, 16'd2, 14'd5);          // ties with the second task
    tick();                                    // starts and completes at once
    tick();                                    // tie: the higher slot starts
    offer(KIND_ARRIVE, 16'd1, 14'd20);         // arrives while a task runs
    repeat (7) tick();                         // drains, ends in idle ticks

    // Random part; the receiver holds off early on so the block backs up.
    gap_max      = 10;
    hold_off_due = 1'b1;
    repeat (933) begin
      if ($urandom_range(0, 5) == 0) random_arrival();
      else tick();
    end
    s_tvalid <= 1'b0;
    @(posedge clk);

    guard = 0;
    while (events_pending != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0 && events_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== nonpreemptive_edf_scheduler.f =====
design/edf_pkg.sv
design/edf_slot_ram.sv
design/nonpreemptive_edf_scheduler.sv
tb/edf_schedule_checker.sv
tb/nonpreemptive_edf_scheduler_tb.sv
